@@ design/tdfa_pkg.sv @@
// shared constants and codes of the table driven dfa
`timescale 1ns / 1ps
package tdfa_pkg;

  localparam int MAX_STATES  = 63;
  localparam int SYMBOL_BITS = 8;

  // field widths of the item and result beats
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam int NUM_STATES = MAX_STATES + 1;
  localparam int TT_ADDR_W  = STATE_W + SYMBOL_BITS;
  localparam int TT_DEPTH   = NUM_STATES << SYMBOL_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP,
    CMD_EDGE,
    CMD_FINAL,
    CMD_RESTART
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK,
    STATUS_FROM_RANGE,
    STATUS_TO_RANGE,
    STATUS_FINAL_RANGE
  } status_e;

  typedef logic [STATE_W-1:0] state_t;

endpackage

@@ design/table_driven_dfa_core.sv @@
// programmable dfa with its transition table in a synchronous memory
`timescale 1ns / 1ps
// Usage:
// - input channel (in_valid_i / in_stall_o) carries one command beat: step on a
//   symbol, add or delete an edge, mark a final state, or go back to state 1
// - output channel (out_valid_o / out_stall_i) returns exactly one result beat per
//   command: accepted flag, current state, final flags and a status code
// - cfg channel (cfg_valid_i / cfg_ready_o) writes state_count; it is always
//   ready and may be written only while no command is in flight
// Command flow:
// - the accept cycle reads the transition table memory at {current state,
//   symbol}; the exec state then applies the command once the output register
//   is free, writes the table back for an edge and loads the output register
// - the result is registered; a new command is not taken until the exec state
//   has applied the current one, as the read of the table memory is registered
// Reset:
// - after rst_ni releases, a clearing pass zeroes the 16384-entry table one
//   entry a cycle; in_stall_o is high until it finishes
// Back-pressure:
// - a new command is taken while a result waits in the output register; its
//   result is held back until the receiver drops out_stall_i
module table_driven_dfa_core
  import tdfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [STATE_W-1:0] cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic [STATE_W-1:0] from_state_i,
  input  logic [STATE_W-1:0] to_state_i,
  input  logic [STATE_W-1:0] final_state_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               in_final_o,
  output logic [STATE_W-1:0] current_state_o,
  output logic [STATE_W-1:0] highest_final_o,
  output logic               has_final_o,
  output logic [STAT_W-1:0]  status_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } fsm_e;

  localparam state_t MaxState = STATE_W'(MAX_STATES);

  fsm_e                   fsm_q;
  logic [TT_ADDR_W-1:0]   clr_cnt_q;
  state_t                 count_q;

  state_t                 now_q, now_d;
  state_t                 top_q, top_d;
  logic                   any_q, any_d;
  logic [NUM_STATES-1:0]  fmap_q, fmap_d;

  cmd_e                   cmd_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  state_t                 from_q, to_q, fin_q;

  logic                   out_valid_q;
  logic                   acc_q, in_final_q, has_final_q;
  state_t                 cur_q, high_q;
  status_e                status_q;

  logic                   acc_d, in_final_d;
  status_e                status_d;

  logic [STATE_W-1:0]     tt_mem [TT_DEPTH];
  state_t                 rdata_q;
  logic                   mem_re, mem_we;
  logic [TT_ADDR_W-1:0]   mem_raddr, mem_waddr;
  state_t                 mem_wdata;

  logic                   in_fire, out_free, exec_fire;
  state_t                 lim;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (fsm_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign exec_fire   = (fsm_q == ST_EXEC) && out_free;

  assign lim = (count_q > MaxState) ? MaxState : count_q;

  // the state is settled before the next accept, so the read sees it directly
  assign mem_re    = in_fire;
  assign mem_raddr = {now_q, symbol_i[SYMBOL_BITS-1:0]};

  always_comb begin
    now_d      = now_q;
    top_d      = top_q;
    any_d      = any_q;
    fmap_d     = fmap_q;
    acc_d      = 1'b0;
    status_d   = STATUS_OK;
    mem_we     = 1'b0;
    mem_waddr  = {from_q, sym_q};
    mem_wdata  = to_q;

    if (fsm_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end

    case (cmd_q)
      CMD_STEP: begin
        if (rdata_q != '0 && rdata_q <= lim) begin
          now_d = rdata_q;
          acc_d = 1'b1;
        end
      end
      CMD_EDGE: begin
        if (from_q > lim) begin
          status_d = STATUS_FROM_RANGE;
        end else if (to_q > lim) begin
          status_d = STATUS_TO_RANGE;
        end else if (exec_fire) begin
          mem_we = 1'b1;
        end
      end
      CMD_FINAL: begin
        if (fin_q > lim) begin
          status_d = STATUS_FINAL_RANGE;
        end else begin
          fmap_d[fin_q] = 1'b1;
          if (!any_q || fin_q > top_q) begin
            top_d = fin_q;
          end
          any_d = 1'b1;
        end
      end
      CMD_RESTART: begin
        now_d = STATE_W'(1);
      end
      default: begin
        now_d = now_q;
      end
    endcase

    in_final_d = fmap_d[now_d];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tt_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_CLEAR;
      clr_cnt_q   <= '0;
      now_q       <= STATE_W'(1);
      top_q       <= '0;
      any_q       <= 1'b0;
      fmap_q      <= '0;
      cmd_q       <= CMD_STEP;
      sym_q       <= '0;
      from_q      <= '0;
      to_q        <= '0;
      fin_q       <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      in_final_q  <= 1'b0;
      has_final_q <= 1'b0;
      cur_q       <= '0;
      high_q      <= '0;
      status_q    <= STATUS_OK;
    end else begin
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (fsm_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == TT_ADDR_W'(TT_DEPTH - 1)) begin
            fsm_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q  <= cmd_e'(cmd_i);
            sym_q  <= symbol_i[SYMBOL_BITS-1:0];
            from_q <= from_state_i;
            to_q   <= to_state_i;
            fin_q  <= final_state_i;
            fsm_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            now_q       <= now_d;
            top_q       <= top_d;
            any_q       <= any_d;
            fmap_q      <= fmap_d;
            acc_q       <= acc_d;
            in_final_q  <= in_final_d;
            cur_q       <= now_d;
            high_q      <= top_d;
            has_final_q <= any_d;
            status_q    <= status_d;
            fsm_q       <= ST_IDLE;
          end
        end
        default: begin
          fsm_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign in_final_o      = in_final_q;
  assign current_state_o = cur_q;
  assign highest_final_o = high_q;
  assign has_final_o     = has_final_q;
  assign status_o        = status_q;

endmodule

@@ design/tdfa_checker.sv @@
// port-level checks of the dfa core and their binding
`timescale 1ns / 1ps
module tdfa_checker
  import tdfa_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               accepted_o,
  input logic               in_final_o,
  input logic [STATE_W-1:0] highest_final_o,
  input logic               has_final_o,
  input logic [STAT_W-1:0]  status_o
);

  // one command in flight: the beat after an accept is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while one is in flight");

  // a stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> status_o == STATUS_OK)
    else $error("accepted step with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_final_o |-> highest_final_o == '0 && !in_final_o)
    else $error("final info without any final state");

endmodule

bind table_driven_dfa_core tdfa_checker u_tdfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .accepted_o     (accepted_o),
  .in_final_o     (in_final_o),
  .highest_final_o(highest_final_o),
  .has_final_o    (has_final_o),
  .status_o       (status_o)
);

@@ dv/table_driven_dfa_core_test.sv @@
// self-checking testbench of the table driven dfa core
`timescale 1ns / 1ps
module table_driven_dfa_core_test;
  import tdfa_pkg::*;

  localparam int QUIET_LIMIT    = 100000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int NUM_PHASES     = 6;

  typedef struct packed {
    cmd_e             cmd;
    logic [SYM_W-1:0] symbol;
    state_t           from_state;
    state_t           to_state;
    state_t           final_state;
  } dfa_cmd_t;

  typedef struct packed {
    logic    accepted;
    logic    in_final;
    state_t  current_state;
    state_t  highest_final;
    logic    has_final;
    status_e status;
  } dfa_res_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  state_t            cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  dfa_cmd_t          cmd_beat    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic              accepted_o;
  logic              in_final_o;
  state_t            current_state_o;
  state_t            highest_final_o;
  logic              has_final_o;
  logic [STAT_W-1:0] status_o;

  // mirror of the automaton
  bit [STATE_W-1:0] edge_tbl [TT_DEPTH];
  bit               final_map [NUM_STATES];
  state_t           state_now = state_t'(1);
  state_t           final_top = '0;
  bit               final_any = 1'b0;
  state_t           count_reg = '0;

  dfa_cmd_t pending_cmds [$];
  dfa_res_t expected_results [$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;

  int unsigned      send_idle    = 0;
  int unsigned      recv_idle    = 0;
  bit               squeeze_arm  = 1'b0;
  bit               squeeze_done = 1'b0;
  int unsigned      squeeze_left = 0;
  logic [SYM_W-1:0] alphabet [4];

  int unsigned phase_count [NUM_PHASES] = '{9, 63, 2, 40, 1, 0};
  int unsigned phase_items [NUM_PHASES] = '{180, 180, 180, 180, 160, 30};

  table_driven_dfa_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_beat.cmd),
    .symbol_i       (cmd_beat.symbol),
    .from_state_i   (cmd_beat.from_state),
    .to_state_i     (cmd_beat.to_state),
    .final_state_i  (cmd_beat.final_state),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .in_final_o     (in_final_o),
    .current_state_o(current_state_o),
    .highest_final_o(highest_final_o),
    .has_final_o    (has_final_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic dfa_res_t dfa_advance(dfa_cmd_t c);
    dfa_res_t    r;
    int unsigned lim;
    state_t      tgt;
    r = '0;
    r.status = STATUS_OK;
    lim = (count_reg > MAX_STATES) ? MAX_STATES : count_reg;
    case (c.cmd)
      CMD_STEP: begin
        tgt = edge_tbl[{state_now, c.symbol[SYMBOL_BITS-1:0]}];
        if (tgt != 0 && tgt <= lim) begin
          state_now = tgt;
          r.accepted = 1'b1;
        end
      end
      CMD_EDGE: begin
        if (c.from_state > lim) r.status = STATUS_FROM_RANGE;
        else if (c.to_state > lim) r.status = STATUS_TO_RANGE;
        else edge_tbl[{c.from_state, c.symbol[SYMBOL_BITS-1:0]}] = c.to_state;
      end
      CMD_FINAL: begin
        if (c.final_state > lim) begin
          r.status = STATUS_FINAL_RANGE;
        end else begin
          final_map[c.final_state] = 1'b1;
          if (!final_any || c.final_state > final_top) final_top = c.final_state;
          final_any = 1'b1;
        end
      end
      default: state_now = state_t'(1);
    endcase
    r.in_final      = final_map[state_now];
    r.current_state = state_now;
    r.highest_final = final_top;
    r.has_final     = final_any;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // mostly in range, now and then anywhere in the field
  function automatic state_t pick_state(int unsigned lim);
    if ($urandom_range(7) == 0) return STATE_W'($urandom);
    return STATE_W'($urandom_range(lim));
  endfunction

  function automatic dfa_cmd_t random_cmd(int unsigned lim);
    dfa_cmd_t    c;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) c.cmd = CMD_STEP;
    else if (r < 78) c.cmd = CMD_EDGE;
    else if (r < 90) c.cmd = CMD_FINAL;
    else c.cmd = CMD_RESTART;
    // a small alphabet keeps steps landing on edges that exist
    c.symbol = SYM_W'($urandom);
    if ($urandom_range(7) != 0) c.symbol = alphabet[$urandom_range(3)];
    c.from_state  = pick_state(lim);
    c.to_state    = ($urandom_range(9) == 0) ? state_t'(0) : pick_state(lim);
    c.final_state = pick_state(lim);
    return c;
  endfunction

  task automatic push_cmd(cmd_e cmd, logic [SYM_W-1:0] sym, state_t from_s, state_t to_s,
                          state_t fin_s);
    dfa_cmd_t c;
    c.cmd         = cmd;
    c.symbol      = sym;
    c.from_state  = from_s;
    c.to_state    = to_s;
    c.final_state = fin_s;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic load_count(state_t value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    count_reg = value;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic fired;
    fired = in_valid_i && !in_stall_o;
    if (fired) expected_results = {expected_results, dfa_advance(cmd_beat)};
    if (!in_valid_i || fired) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
        cmd_beat   <= pending_cmds.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    dfa_res_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", want.accepted, accepted_o);
        check_field("in_final", want.in_final, in_final_o);
        check_field("current_state", want.current_state, current_state_o);
        check_field("highest_final", want.highest_final, highest_final_o);
        check_field("has_final", want.has_final, has_final_o);
        check_field("status", want.status, status_o);
      end
    end
    if (squeeze_left != 0) begin
      out_stall_i  <= 1'b1;
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_arm && !squeeze_done) begin
      // long hold-off so the core backs up into its input
      out_stall_i  <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle = 20;
    recv_idle = 81;

    // state count still at its reset value of zero
    push_cmd(CMD_FINAL, 8'h00, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_EDGE, 8'hff, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_EDGE, 8'h00, 6'd1, 6'd0, 6'd0);
    push_cmd(CMD_EDGE, 8'h00, 6'd0, 6'd63, 6'd0);
    push_cmd(CMD_EDGE, 8'haa, 6'd5, 6'd9, 6'd0);
    push_cmd(CMD_FINAL, 8'h00, 6'd0, 6'd0, 6'd63);
    push_cmd(CMD_STEP, 8'h00, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_RESTART, 8'hff, 6'd63, 6'd63, 6'd63);
    drain();

    load_count(6'd63);
    push_cmd(CMD_EDGE, 8'h00, 6'd1, 6'd63, 6'd0);
    push_cmd(CMD_EDGE, 8'hff, 6'd63, 6'd1, 6'd0);
    push_cmd(CMD_EDGE, 8'h55, 6'd63, 6'd63, 6'd0);
    push_cmd(CMD_STEP, 8'h00, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_FINAL, 8'h00, 6'd0, 6'd0, 6'd63);
    push_cmd(CMD_STEP, 8'h55, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_STEP, 8'hff, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_STEP, 8'h12, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_RESTART, 8'h00, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_STEP, 8'h00, 6'd0, 6'd0, 6'd0);
    // zero target deletes the edge
    push_cmd(CMD_EDGE, 8'h00, 6'd1, 6'd0, 6'd0);
    push_cmd(CMD_RESTART, 8'h00, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_STEP, 8'h00, 6'd0, 6'd0, 6'd0);
    push_cmd(CMD_FINAL, 8'h00, 6'd0, 6'd0, 6'd5);
    push_cmd(CMD_EDGE, 8'h00, 6'd1, 6'd63, 6'd0);
    // leaves state 63 current, above the next count
    push_cmd(CMD_STEP, 8'h00, 6'd0, 6'd0, 6'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_count(state_t'(phase_count[p]));
      send_idle = (p < 2) ? 20 : (p < 4) ? 81 : 0;
      recv_idle = (p < 2) ? 81 : (p < 4) ? 20 : 0;
      alphabet[0] = 8'h00;
      alphabet[1] = 8'hff;
      alphabet[2] = SYM_W'($urandom);
      alphabet[3] = SYM_W'($urandom);
      if (p == 0) squeeze_arm = 1'b1;
      for (int n = 0; n < phase_items[p]; n++) begin
        pending_cmds = {pending_cmds, random_cmd(phase_count[p])};
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
